### hdl/adc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_pkg
// shared types and constants of the anisotropic distance check
// ----------------------------------------------------------------------------
package adc_pkg;

   // configuration register map
   typedef enum logic [2:0] {
      CSR_ROT_00,
      CSR_ROT_01,
      CSR_ROT_10,
      CSR_ROT_11,
      CSR_INV_SCALE_X,
      CSR_INV_SCALE_Y,
      CSR_RADIUS,
      CSR_MODE
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // arithmetic widths
   localparam int ROT_WIDTH   = 16;
   localparam int ROT_FRAC    = 14;
   localparam int SCALE_WIDTH = 24;
   localparam int SCALE_FRAC  = 16;
   localparam int DIST_WIDTH  = 32;
   localparam int RAD_WIDTH   = 2 * DIST_WIDTH;
   localparam int MODE_WIDTH  = 2;

   // mode and action codes
   localparam logic [MODE_WIDTH-1:0] MODE_ISO = 2'd0;
   localparam int                    MODE_ROT_BIT = 1;
   localparam logic                  ACTION_POINTS = 1'b0;

   typedef struct packed {
      logic signed [ROT_WIDTH-1:0] rot_00;
      logic signed [ROT_WIDTH-1:0] rot_01;
      logic signed [ROT_WIDTH-1:0] rot_10;
      logic signed [ROT_WIDTH-1:0] rot_11;
      logic [SCALE_WIDTH-1:0]      inv_scale_x;
      logic [SCALE_WIDTH-1:0]      inv_scale_y;
      logic [DIST_WIDTH-1:0]       radius;
      logic [MODE_WIDTH-1:0]       mode;
   } cfg_type;

   // identity rotation, unit scale, widest radius, isotropic
   localparam cfg_type CFG_RESET = '{
      rot_00:      16'sd16384,
      rot_01:      16'sd0,
      rot_10:      16'sd0,
      rot_11:      16'sd16384,
      inv_scale_x: 24'd65536,
      inv_scale_y: 24'd65536,
      radius:      32'hFFFF_FFFF,
      mode:        2'd0
   };

endpackage
`default_nettype wire

### hdl/adc_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_csr
// configuration register file, written through the csr channel
// ----------------------------------------------------------------------------
module adc_csr
   import adc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_00:      cfg_in.rot_00      = csr_data[ROT_WIDTH-1:0];
            CSR_ROT_01:      cfg_in.rot_01      = csr_data[ROT_WIDTH-1:0];
            CSR_ROT_10:      cfg_in.rot_10      = csr_data[ROT_WIDTH-1:0];
            CSR_ROT_11:      cfg_in.rot_11      = csr_data[ROT_WIDTH-1:0];
            CSR_INV_SCALE_X: cfg_in.inv_scale_x = csr_data[SCALE_WIDTH-1:0];
            CSR_INV_SCALE_Y: cfg_in.inv_scale_y = csr_data[SCALE_WIDTH-1:0];
            CSR_RADIUS:      cfg_in.radius      = csr_data[DIST_WIDTH-1:0];
            CSR_MODE:        cfg_in.mode        = csr_data[MODE_WIDTH-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### hdl/adc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_front
// increment, rotation, per-axis scaling and sum of squares, eight stages
// ----------------------------------------------------------------------------
module adc_front
   import adc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic                          in_action,
   input  wire logic signed [COORD_WIDTH-1:0] in_first_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_first_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_second_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_second_y,
   input  wire cfg_type                       cfg,
   output logic                               out_valid,
   output logic [RAD_WIDTH-1:0]               out_sum,
   output logic                               out_sat
);

   localparam int STAGES = 8;
   localparam int DW     = COORD_WIDTH + 1;                 // increment
   localparam int PW     = DW + ROT_WIDTH;                  // rotation product
   localparam int RW     = PW + 1 - ROT_FRAC;               // rotated component
   localparam int MEXT   = (RW > SCALE_WIDTH) ? RW : SCALE_WIDTH + 1;
   localparam int HIW    = MEXT - SCALE_WIDTH;
   localparam int PRW    = MEXT + SCALE_WIDTH;              // full scale product
   localparam int MXW    = (RW > DIST_WIDTH) ? RW : DIST_WIDTH + 1;
   localparam int LOW    = 2 * SCALE_WIDTH;                 // low partial product

   logic [STAGES-1:0] vld_ff;

   // stage 1: increment
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;

   always_comb begin
      if (in_action == ACTION_POINTS) begin
         dx_in = {in_first_x[COORD_WIDTH-1], in_first_x}
               - {in_second_x[COORD_WIDTH-1], in_second_x};
         dy_in = {in_first_y[COORD_WIDTH-1], in_first_y}
               - {in_second_y[COORD_WIDTH-1], in_second_y};
      end else begin
         dx_in = {in_first_x[COORD_WIDTH-1], in_first_x};
         dy_in = {in_first_y[COORD_WIDTH-1], in_first_y};
      end
   end

   // stage 2: rotation products, increment carried for the unrotated modes
   logic signed [PW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [PW-1:0] p00_in, p01_in, p10_in, p11_in;
   logic signed [DW-1:0] dx2_ff, dy2_ff;

   assign p00_in = dx_ff * cfg.rot_00;
   assign p01_in = dx_ff * cfg.rot_01;
   assign p10_in = dy_ff * cfg.rot_10;
   assign p11_in = dy_ff * cfg.rot_11;

   // stage 3: dot products floored by 2^14, or the plain increment
   logic signed [PW:0]   u_sum, v_sum;
   logic signed [RW-1:0] vx_ff, vy_ff, vx_in, vy_in;

   assign u_sum = {p00_ff[PW-1], p00_ff} + {p10_ff[PW-1], p10_ff};
   assign v_sum = {p01_ff[PW-1], p01_ff} + {p11_ff[PW-1], p11_ff};

   always_comb begin
      if (cfg.mode[MODE_ROT_BIT]) begin
         vx_in = u_sum[PW:ROT_FRAC];
         vy_in = v_sum[PW:ROT_FRAC];
      end else begin
         vx_in = {{(RW - DW){dx2_ff[DW-1]}}, dx2_ff};
         vy_in = {{(RW - DW){dy2_ff[DW-1]}}, dy2_ff};
      end
   end

   // stage 4: magnitudes
   logic [RW-1:0] mx_ff, my_ff, mx_in, my_in;

   assign mx_in = vx_ff[RW-1] ? (~vx_ff + 1'b1) : vx_ff;
   assign my_in = vy_ff[RW-1] ? (~vy_ff + 1'b1) : vy_ff;

   // stage 5: scale partial products split at the 24-bit boundary
   logic [MEXT-1:0] mx_ext, my_ext;
   logic [LOW-1:0]  lox_ff, loy_ff, lox_in, loy_in;
   logic [MEXT-1:0] hix_ff, hiy_ff, hix_in, hiy_in;
   logic [RW-1:0]   mx5_ff, my5_ff;

   assign mx_ext = MEXT'(mx_ff);
   assign my_ext = MEXT'(my_ff);
   assign lox_in = mx_ext[SCALE_WIDTH-1:0] * cfg.inv_scale_x;
   assign loy_in = my_ext[SCALE_WIDTH-1:0] * cfg.inv_scale_y;
   assign hix_in = HIW'(mx_ext[MEXT-1:SCALE_WIDTH]) * cfg.inv_scale_x;
   assign hiy_in = HIW'(my_ext[MEXT-1:SCALE_WIDTH]) * cfg.inv_scale_y;

   // stage 6: combine and truncate by 2^16 when scaled, then check range
   logic [PRW-1:0]        prod_x, prod_y;
   logic [MXW-1:0]        mx_wide, my_wide;
   logic [DIST_WIDTH-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic                  sat6_ff, sat6_in;

   assign prod_x  = {hix_ff, {SCALE_WIDTH{1'b0}}} + PRW'(lox_ff);
   assign prod_y  = {hiy_ff, {SCALE_WIDTH{1'b0}}} + PRW'(loy_ff);
   assign mx_wide = MXW'(mx5_ff);
   assign my_wide = MXW'(my5_ff);

   always_comb begin
      if (cfg.mode != MODE_ISO) begin
         cx_in   = prod_x[SCALE_FRAC +: DIST_WIDTH];
         cy_in   = prod_y[SCALE_FRAC +: DIST_WIDTH];
         sat6_in = (|prod_x[PRW-1:SCALE_FRAC+DIST_WIDTH])
                 | (|prod_y[PRW-1:SCALE_FRAC+DIST_WIDTH]);
      end else begin
         cx_in   = mx_wide[DIST_WIDTH-1:0];
         cy_in   = my_wide[DIST_WIDTH-1:0];
         sat6_in = (|mx_wide[MXW-1:DIST_WIDTH]) | (|my_wide[MXW-1:DIST_WIDTH]);
      end
   end

   // stage 7: squares
   logic [RAD_WIDTH-1:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic                 sat7_ff;

   assign sqx_in = cx_ff * cx_ff;
   assign sqy_in = cy_ff * cy_ff;

   // stage 8: sum of squares, carry out saturates
   logic [RAD_WIDTH:0]   sum_in;
   logic [RAD_WIDTH-1:0] sum_ff;
   logic                 sat8_ff, sat8_in;

   assign sum_in  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sat8_in = sat7_ff | sum_in[RAD_WIDTH];

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         dx2_ff  <= dx_ff;
         dy2_ff  <= dy_ff;
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         lox_ff  <= lox_in;
         loy_ff  <= loy_in;
         hix_ff  <= hix_in;
         hiy_ff  <= hiy_in;
         mx5_ff  <= mx_ff;
         my5_ff  <= my_ff;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         sat6_ff <= sat6_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         sat7_ff <= sat6_ff;
         sum_ff  <= sum_in[RAD_WIDTH-1:0];
         sat8_ff <= sat8_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_sum   = sum_ff;
   assign out_sat   = sat8_ff;

endmodule
`default_nettype wire

### hdl/adc_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_isqrt
// pipelined floor square root, one root bit decided per stage
// ----------------------------------------------------------------------------
module adc_isqrt
   import adc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [RAD_WIDTH-1:0]  in_radicand,
   input  wire logic                  in_sat,
   output logic                       out_valid,
   output logic [DIST_WIDTH-1:0]      out_root,
   output logic                       out_sat
);

   localparam int TW = RAD_WIDTH + 2;

   logic                  vld_ff  [DIST_WIDTH];
   logic                  sat_ff  [DIST_WIDTH];
   logic [RAD_WIDTH-1:0]  rem_ff  [DIST_WIDTH];
   logic [DIST_WIDTH-1:0] root_ff [DIST_WIDTH];
   logic [RAD_WIDTH-1:0]  rem_in  [DIST_WIDTH];
   logic [DIST_WIDTH-1:0] root_in [DIST_WIDTH];

   for (genvar k = 0; k < DIST_WIDTH; k++) begin : g_stage
      localparam int BIT = DIST_WIDTH - 1 - k;

      logic                  vld_prev;
      logic                  sat_prev;
      logic [RAD_WIDTH-1:0]  rem_prev;
      logic [DIST_WIDTH-1:0] root_prev;
      logic [TW-1:0]         trial;
      logic                  fits;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign sat_prev  = in_sat;
         assign rem_prev  = in_radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign sat_prev  = sat_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (root + 2^bit)^2 - root^2
      assign trial      = (TW'(root_prev) << (BIT + 1)) + (TW'(1) << (2 * BIT));
      assign fits       = {2'b00, rem_prev} >= trial;
      assign rem_in[k]  = fits ? (rem_prev - trial[RAD_WIDTH-1:0]) : rem_prev;
      assign root_in[k] = fits ? (root_prev | (DIST_WIDTH'(1) << BIT)) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sat_ff[k]  <= sat_prev;
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = vld_ff[DIST_WIDTH-1];
   assign out_root  = root_ff[DIST_WIDTH-1];
   assign out_sat   = sat_ff[DIST_WIDTH-1];

   // a stall freezes the last stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[DIST_WIDTH-1]) && $stable(root_ff[DIST_WIDTH-1]))
      else $error("root pipeline moved during a stall");

   // the first stage can only decide the top root bit
   a_first_bit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> root_ff[0][DIST_WIDTH-2:0] == '0)
      else $error("low root bits set in first stage");

   // finished root is the floor: remainder at most twice the root
   a_floor_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIST_WIDTH-1] && !sat_ff[DIST_WIDTH-1]
         |-> rem_ff[DIST_WIDTH-1] <= RAD_WIDTH'({root_ff[DIST_WIDTH-1], 1'b0}))
      else $error("square root remainder out of range");

endmodule
`default_nettype wire

### hdl/anisotropic_distance_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anisotropic_distance_check
// normalized distance of a 2-D increment with radius check
// ----------------------------------------------------------------------------
// pipeline: 8 arithmetic stages, 32 square root stages with one root bit each,
//   one output register
// throughput: one request per cycle; a stalled result holds the whole pipeline
// reset: synchronous, clears all valid bits and loads identity rotation,
//   unit scales, widest radius and isotropic mode
// ----------------------------------------------------------------------------
module anisotropic_distance_check
   import adc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   // request: first_x, first_y, second_x, second_y, zero fill
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]          req_tdata,
   // request user: action
   input  wire logic                                        req_tuser,
   // result: distance
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   output logic [DIST_WIDTH-1:0]                            rsp_tdata,
   // result user: within_res
   output logic                                             rsp_tuser,
   // configuration writes
   input  wire logic                                        csr_valid,
   output logic                                             csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]                  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]                   csr_data
);

   localparam int W = COORD_WIDTH;

   cfg_type               cfg;
   logic                  adv;
   logic                  front_valid;
   logic [RAD_WIDTH-1:0]  front_sum;
   logic                  front_sat;
   logic                  root_valid;
   logic [DIST_WIDTH-1:0] root_value;
   logic                  root_sat;

   logic                  rsp_valid_ff;
   logic [DIST_WIDTH-1:0] dist_ff, dist_in;
   logic                  within_ff, within_in;

   // pipeline moves unless a result is waiting
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   adc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   adc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid),
      .in_action   (req_tuser),
      .in_first_x  (req_tdata[W-1:0]),
      .in_first_y  (req_tdata[2*W-1:W]),
      .in_second_x (req_tdata[3*W-1:2*W]),
      .in_second_y (req_tdata[4*W-1:3*W]),
      .cfg         (cfg),
      .out_valid   (front_valid),
      .out_sum     (front_sum),
      .out_sat     (front_sat)
   );

   adc_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (front_valid),
      .in_radicand (front_sum),
      .in_sat      (front_sat),
      .out_valid   (root_valid),
      .out_root    (root_value),
      .out_sat     (root_sat)
   );

   // saturate and compare against radius
   assign dist_in   = root_sat ? {DIST_WIDTH{1'b1}} : root_value;
   assign within_in = dist_in <= cfg.radius;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff   <= dist_in;
         within_ff <= within_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dist_ff;
   assign rsp_tuser  = within_ff;

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// streaming regression of the anisotropic distance check: a directed table
// and randomized configuration phases, each result checked in order against
// a typed expected value or a bit-exact distance predictor
// ----------------------------------------------------------------------------
module tb_top
   import adc_pkg::*;
();

   localparam int COORD_WIDTH     = 32;
   localparam int REQ_WIDTH       = ((4 * COORD_WIDTH + 7) / 8) * 8;
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_REQUESTS  = 250;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 60;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  within_res;
   } dist_result_type;

   typedef struct {
      logic                  is_csr;
      csr_index_type         idx;
      logic [31:0]           data;
      logic                  action;
      logic [31:0]           fx;
      logic [31:0]           fy;
      logic [31:0]           sx;
      logic [31:0]           sy;
      logic                  typed;
      dist_result_type       result;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_WIDTH-1:0]       req_tdata = '0;
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [DIST_WIDTH-1:0]      rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   cfg_type          cfg_model = CFG_RESET;
   dist_result_type  expected_distances[$];
   stim_row_type     directed_rows[$];
   int               error_count = 0;
   int               quiet_cycles = 0;
   int               stall_left = 0;
   bit               idle_enable = 1'b1;

   anisotropic_distance_check #(
      .COORD_WIDTH(COORD_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // first_x, first_y, second_x, second_y
      .req_tuser  (req_tuser),   // action
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // distance
      .rsp_tuser  (rsp_tuser),   // within_res
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor square root, one result bit per pass
   function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (32'd1 << i);
         if (64'(trial) * 64'(trial) <= n) root = trial;
      end
      return root;
   endfunction

   // normalized distance and radius flag under the current register copy
   function automatic dist_result_type predict_distance(input logic action,
         input logic [31:0] fx, input logic [31:0] fy,
         input logic [31:0] sx, input logic [31:0] sy);
      longint           dx;
      longint           dy;
      longint           u;
      longint           v;
      logic [127:0]     mx;
      logic [127:0]     my;
      logic [63:0]      sqx;
      logic [63:0]      sqy;
      logic [64:0]      sum;
      logic             sat;
      dist_result_type  res;
      dx = longint'($signed(fx));
      dy = longint'($signed(fy));
      if (action == ACTION_POINTS) begin
         dx = dx - longint'($signed(sx));
         dy = dy - longint'($signed(sy));
      end
      // row vector times matrix, floored back to Q16.16
      if (cfg_model.mode[MODE_ROT_BIT]) begin
         u = (dx * longint'($signed(cfg_model.rot_00))
            + dy * longint'($signed(cfg_model.rot_10))) >>> ROT_FRAC;
         v = (dx * longint'($signed(cfg_model.rot_01))
            + dy * longint'($signed(cfg_model.rot_11))) >>> ROT_FRAC;
         dx = u;
         dy = v;
      end
      mx = (dx < 0) ? 128'(-dx) : 128'(dx);
      my = (dy < 0) ? 128'(-dy) : 128'(dy);
      // per-axis reciprocal, truncated toward zero
      if (cfg_model.mode != MODE_ISO) begin
         mx = (mx * cfg_model.inv_scale_x) >> SCALE_FRAC;
         my = (my * cfg_model.inv_scale_y) >> SCALE_FRAC;
      end
      sat = (|mx[127:32]) || (|my[127:32]);
      sqx = 64'(mx[31:0]) * 64'(mx[31:0]);
      sqy = 64'(my[31:0]) * 64'(my[31:0]);
      sum = 65'(sqx) + 65'(sqy);
      if (sum[64]) sat = 1'b1;
      res.distance = sat ? '1 : floor_sqrt(sum[63:0]);
      res.within_res = (res.distance <= cfg_model.radius);
      return res;
   endfunction

   // mirror of one register write
   function automatic void apply_csr(input csr_index_type idx, input logic [31:0] data);
      case (idx)
         CSR_ROT_00:      cfg_model.rot_00 = data[ROT_WIDTH-1:0];
         CSR_ROT_01:      cfg_model.rot_01 = data[ROT_WIDTH-1:0];
         CSR_ROT_10:      cfg_model.rot_10 = data[ROT_WIDTH-1:0];
         CSR_ROT_11:      cfg_model.rot_11 = data[ROT_WIDTH-1:0];
         CSR_INV_SCALE_X: cfg_model.inv_scale_x = data[SCALE_WIDTH-1:0];
         CSR_INV_SCALE_Y: cfg_model.inv_scale_y = data[SCALE_WIDTH-1:0];
         CSR_RADIUS:      cfg_model.radius = data[DIST_WIDTH-1:0];
         default:         cfg_model.mode = data[MODE_WIDTH-1:0];
      endcase
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type idx,
         input logic [31:0] data);
      stim_row_type row;
      row = '{idx: CSR_ROT_00, default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   function automatic stim_row_type req_row(input logic action,
         input logic [31:0] fx, input logic [31:0] fy,
         input logic [31:0] sx, input logic [31:0] sy,
         input logic typed, input logic [31:0] distance, input logic within_res);
      stim_row_type row;
      row = '{idx: CSR_ROT_00, default: '0};
      row.idx = CSR_ROT_00;
      row.action = action;
      row.fx = fx;
      row.fy = fy;
      row.sx = sx;
      row.sy = sy;
      row.typed = typed;
      row.result.distance = distance;
      row.result.within_res = within_res;
      return row;
   endfunction

   // random coordinate: mostly small and medium, some full range and extremes
   function automatic logic [31:0] rand_coord();
      logic [31:0] c;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: c = 32'h7FFF_FFFF;
               1: c = 32'h8000_0000;
               2: c = 32'h0000_0000;
               default: c = 32'hFFFF_FFFF;
            endcase
         end
         1, 2: c = $urandom;
         3, 4, 5, 6: c = 32'(int'($urandom_range(0, 2**21 - 1)) - 2**20);
         default: c = 32'(int'($urandom_range(0, 2**28 - 1)) - 2**27);
      endcase
      return c;
   endfunction

   // register value for one phase; unused upper bits carry noise
   function automatic logic [31:0] phase_csr_data(input int phase, input csr_index_type idx);
      logic [31:0] noise;
      logic [31:0] d;
      noise = $urandom;
      case (idx)
         CSR_ROT_00, CSR_ROT_01, CSR_ROT_10, CSR_ROT_11: begin
            if (phase == 0) d = 32'h0000_7FFF;
            else if (phase == 1) d = 32'h0000_8000;
            else begin
               case ($urandom_range(0, 4))
                  0: d = 32'h0000_4000;
                  1: d = 32'h0000_C000;
                  2: d = 32'h0000_0000;
                  default: d = $urandom_range(0, 16'hFFFF);
               endcase
            end
            d[31:ROT_WIDTH] = noise[31:ROT_WIDTH];
         end
         CSR_INV_SCALE_X, CSR_INV_SCALE_Y: begin
            if (phase == 0) d = 32'h00FF_FFFF;
            else if (phase == 1) d = (idx == CSR_INV_SCALE_X) ? 32'h0 : 32'h0001_0000;
            else begin
               case ($urandom_range(0, 5))
                  0: d = 32'h0000_0000;
                  1: d = 32'h0001_0000;
                  2: d = $urandom_range(0, 24'hFF_FFFF);
                  default: d = $urandom_range(0, 24'h03_FFFF);
               endcase
            end
            d[31:SCALE_WIDTH] = noise[31:SCALE_WIDTH];
         end
         CSR_RADIUS: begin
            if (phase == 0) d = 32'hFFFF_FFFF;
            else if (phase == 1) d = 32'h0000_0000;
            else if ($urandom_range(0, 2) == 0) d = $urandom;
            else d = $urandom_range(0, 24'hFF_FFFF);
         end
         default: begin
            if (phase == 0) d = 32'd3;
            else d = 32'(phase % 4);
            if (phase == 1) d = 32'd2;
            d[31:MODE_WIDTH] = noise[31:MODE_WIDTH];
         end
      endcase
      return d;
   endfunction

   // let the pipeline empty before touching registers
   task automatic wait_drain(input int extra);
      req_tvalid <= 1'b0;
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one request, with an optional gap before it
   task automatic send_request(input logic action,
         input logic [31:0] fx, input logic [31:0] fy,
         input logic [31:0] sx, input logic [31:0] sy,
         input logic typed, input dist_result_type typed_result);
      dist_result_type exp_res;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      exp_res = typed ? typed_result : predict_distance(action, fx, fy, sx, sy);
      req_tvalid <= 1'b1;
      req_tdata <= {sy, sx, fy, fx};
      req_tuser <= action;
      do @(posedge clock); while (!req_tready);
      expected_distances.push_back(exp_res);
   endtask

   // result side: random stall bursts and in-order check
   always @(posedge clock) begin
      dist_result_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_distances.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < REPORT_LIMIT)
                  $display("unexpected result: distance %h within_res %b", rsp_tdata,
                     rsp_tuser);
            end else begin
               exp_res = expected_distances.pop_front();
               if (rsp_tdata !== exp_res.distance || rsp_tuser !== exp_res.within_res) begin
                  error_count <= error_count + 1;
                  if (error_count < REPORT_LIMIT)
                     $display("mismatch: distance exp %h got %h, within_res exp %b got %b",
                        exp_res.distance, rsp_tdata, exp_res.within_res, rsp_tuser);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 12);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("anisotropic_distance_check regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type row;
      // reset defaults: identity, unit scale, widest radius, isotropic
      directed_rows.push_back(req_row(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(req_row(1'b1, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0,
         1'b1, 32'h0005_0000, 1'b1));
      // second point ignored for an increment request
      directed_rows.push_back(req_row(1'b1, 32'h0003_0000, 32'h0004_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 1'b1, 32'h0005_0000, 1'b1));
      directed_rows.push_back(req_row(1'b0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
         1'b1, 32'hFFFF_FFFF, 1'b1));
      // sum of squares overflow, saturated yet within widest radius
      directed_rows.push_back(req_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1));
      directed_rows.push_back(req_row(1'b1, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
         1'b1, 32'h8000_0000, 1'b1));
      directed_rows.push_back(req_row(1'b1, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0,
         1'b1, 32'h1, 1'b1));
      // zero radius
      directed_rows.push_back(csr_row(CSR_RADIUS, 32'h0));
      directed_rows.push_back(req_row(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(req_row(1'b1, 32'h1, 32'h0, 32'h0, 32'h0, 1'b1, 32'h1, 1'b0));
      directed_rows.push_back(req_row(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0));
      // radius at the boundary
      directed_rows.push_back(csr_row(CSR_RADIUS, 32'h0005_0000));
      directed_rows.push_back(req_row(1'b0, 32'h0004_0000, 32'h0006_0000, 32'h0001_0000,
         32'h0002_0000, 1'b1, 32'h0005_0000, 1'b1));
      directed_rows.push_back(req_row(1'b1, 32'h0005_0000, 32'h1, 32'h0, 32'h0,
         1'b0, 32'h0, 1'b0));
      // scaled mode, zero reciprocal on x, one half on y
      directed_rows.push_back(csr_row(CSR_MODE, 32'd1));
      directed_rows.push_back(csr_row(CSR_INV_SCALE_X, 32'h0));
      directed_rows.push_back(csr_row(CSR_INV_SCALE_Y, 32'h0000_8000));
      directed_rows.push_back(req_row(1'b1, 32'h7FFF_FFFF, 32'h000A_0000, 32'h0, 32'h0,
         1'b1, 32'h0005_0000, 1'b1));
      // widest reciprocal, scaled component overflow
      directed_rows.push_back(csr_row(CSR_INV_SCALE_X, 32'h00FF_FFFF));
      directed_rows.push_back(req_row(1'b1, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
         1'b0, 32'h0, 1'b0));
      directed_rows.push_back(req_row(1'b1, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
         1'b1, 32'hFFFF_FFFF, 1'b0));
      // mode three acts as rotate then scale, swap matrix
      directed_rows.push_back(csr_row(CSR_MODE, 32'd3));
      directed_rows.push_back(csr_row(CSR_ROT_00, 32'h0));
      directed_rows.push_back(csr_row(CSR_ROT_01, 32'h0000_4000));
      directed_rows.push_back(csr_row(CSR_ROT_10, 32'h0000_4000));
      directed_rows.push_back(csr_row(CSR_ROT_11, 32'h0));
      directed_rows.push_back(csr_row(CSR_INV_SCALE_X, 32'h0001_0000));
      directed_rows.push_back(csr_row(CSR_INV_SCALE_Y, 32'h0));
      directed_rows.push_back(req_row(1'b1, 32'h0003_0000, 32'h0, 32'h0, 32'h0,
         1'b0, 32'h0, 1'b0));
      directed_rows.push_back(req_row(1'b1, 32'h0, 32'h0003_0000, 32'h0, 32'h0,
         1'b0, 32'h0, 1'b0));
      // extreme matrix entries, negative products floored
      directed_rows.push_back(csr_row(CSR_MODE, 32'd2));
      directed_rows.push_back(csr_row(CSR_ROT_00, 32'h0000_8000));
      directed_rows.push_back(csr_row(CSR_ROT_01, 32'h0000_7FFF));
      directed_rows.push_back(csr_row(CSR_ROT_10, 32'h0000_7FFF));
      directed_rows.push_back(csr_row(CSR_ROT_11, 32'h0000_8000));
      directed_rows.push_back(csr_row(CSR_INV_SCALE_Y, 32'h0001_0000));
      directed_rows.push_back(csr_row(CSR_RADIUS, 32'hFFFF_FFFF));
      directed_rows.push_back(req_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(req_row(1'b0, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0,
         1'b0, 32'h0, 1'b0));
      directed_rows.push_back(req_row(1'b1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0,
         1'b0, 32'h0, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            wait_drain(SETTLE_CYCLES);
            write_csr(row.idx, row.data);
         end else begin
            send_request(row.action, row.fx, row.fy, row.sx, row.sy, row.typed, row.result);
         end
      end

      // random phases, each with a fresh register set; the last one without idling
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drain(SETTLE_CYCLES);
         idle_enable = (phase != NUM_PHASES - 1);
         for (int r = 0; r < 8; r++)
            write_csr(csr_index_type'(r), phase_csr_data(phase, csr_index_type'(r)));
         for (int n = 0; n < PHASE_REQUESTS; n++)
            send_request(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), 1'b0, '0);
      end

      wait_drain(TAIL_CYCLES);
      if (error_count == 0 && expected_distances.size() == 0) begin
         $display("anisotropic_distance_check regression: pass");
      end else begin
         $display("anisotropic_distance_check regression: fail");
      end
      $finish;
   end

endmodule
